// ----- design/cksz_pkg.sv -----
// Shared constants and types for the CRC-32 keyed size table.
// No dependencies; imported by cksz_crc and the top level (cksz_ram does not use it).
package cksz_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TBL_CW      = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W     = 64;

    // Reflected CRC-32
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // Command codes
    localparam logic [1:0] CMD_GET_KEY  = 2'd0;
    localparam logic [1:0] CMD_SET_KEY  = 2'd1;
    localparam logic [1:0] CMD_GET_HASH = 2'd2;
    localparam logic [1:0] CMD_SET_HASH = 2'd3;

    // Control from the sequencer to the CRC unit
    typedef struct packed {
        logic fold_en;   // fold the current key byte
        logic restart;   // key finished: go back to all ones
    } t_crc_ctl;

endpackage

// ----- design/cksz_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module cksz_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/cksz_crc.sv -----
// Running reflected CRC-32 over key bytes, one byte per cycle while fold_en is set.
// Depends on cksz_pkg for the polynomial and the control struct.
module cksz_crc
    import cksz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_ctl    i_ctl,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_hash     // finished hash if this byte were the last
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] fold;

    // Byte-wise fold: eight shift/xor steps on the low byte
    always_comb begin
        logic [31:0] c;
        c = {24'd0, r_crc[7:0] ^ i_byte};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = CRC_POLY ^ (c >> 1);
            end else begin
                c = c >> 1;
            end
        end
        fold = c ^ (r_crc >> 8);
    end

    assign o_hash = fold ^ CRC_ONES;
    assign n_crc  = i_ctl.restart ? CRC_ONES : fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_ONES;
        end else if (i_ctl.fold_en) begin
            r_crc <= n_crc;
        end
    end

endmodule

// ----- design/crc32_keyed_size_table.sv -----
// Top level of the CRC-32 keyed size table: sequencer, scan and result register.
// Depends on cksz_pkg, cksz_crc and cksz_ram.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------------
//  input   | i_in_valid / o_in_ready   | i_command i_key_byte i_key_last i_given_hash
//          |                           | i_new_size
//  output  | o_out_valid / i_out_ready | o_size_value o_found o_table_full o_key_hash
//
// A key byte that is not last is folded into the CRC and gives no result.
// A table operation scans the stored entries through the entry RAM, one read
// per cycle, and compares each entry once its registered read data returns.
// Reset (synchronous, active low) empties the table and restores the CRC.
// A finished result waits in the output register; the next item is taken
// meanwhile, and a further result holds the block until that register frees.
module crc32_keyed_size_table
    import cksz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_key_byte,
    input  logic        i_key_last,
    input  logic [31:0] i_given_hash,
    input  logic [31:0] i_new_size,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_size_value,
    output logic        o_found,
    output logic        o_table_full,
    output logic [31:0] o_key_hash
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [TBL_CW-1:0] r_count;
    logic [TBL_CW-1:0] r_issue;
    logic              r_pend;
    logic [TBL_AW-1:0] r_pend_idx;
    logic              r_is_set;
    logic [31:0]       r_hash;
    logic [31:0]       r_size_in;
    logic              r_hit;
    logic [TBL_AW-1:0] r_hit_idx;
    logic [31:0]       r_hit_size;

    logic              r_out_valid;
    logic [31:0]       r_out_size;
    logic              r_out_found;
    logic              r_out_full;
    logic [31:0]       r_out_hash;

    logic              in_acc;
    logic              is_hash_cmd;
    logic              table_op;
    logic [31:0]       key_hash;
    t_crc_ctl          crc_ctl;

    logic              issuing;
    logic              match;
    logic              out_free;
    logic              fin_go;
    logic              tbl_full;
    logic              ram_we;
    logic [TBL_AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    // Input handshake and command decode
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign is_hash_cmd = (i_command == CMD_GET_HASH) || (i_command == CMD_SET_HASH);
    assign table_op    = in_acc && (is_hash_cmd || i_key_last);

    assign crc_ctl.fold_en = in_acc && !is_hash_cmd;
    assign crc_ctl.restart = i_key_last;

    cksz_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .i_byte  (i_key_byte),
        .o_hash  (key_hash)
    );

    // Scan: one read a cycle, compare the entry read the cycle before
    assign issuing = (r_state == S_SCAN) && (r_issue < r_count);
    assign match   = r_pend && (ram_rdata[63:32] == r_hash);

    // Finish: update the table and load the result once the output is free
    assign out_free = !r_out_valid || i_out_ready;
    assign fin_go   = (r_state == S_FIN) && out_free;
    assign tbl_full = (r_count == TBL_CW'(TABLE_DEPTH));

    assign ram_we    = fin_go && r_is_set && (r_hit || !tbl_full);
    assign ram_waddr = r_hit ? r_hit_idx : r_count[TBL_AW-1:0];
    assign ram_wdata = {r_hash, r_size_in};

    cksz_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issuing),
        .i_raddr (r_issue[TBL_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (table_op) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (match || (!issuing && !r_pend)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issuing && !match;
            if (ram_we && !r_hit) begin
                r_count <= r_count + 1'b1;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and scan payload
    always_ff @(posedge i_clk) begin
        if (table_op) begin
            r_is_set  <= (i_command == CMD_SET_KEY) || (i_command == CMD_SET_HASH);
            r_hash    <= is_hash_cmd ? i_given_hash : key_hash;
            r_size_in <= i_new_size;
            r_issue   <= '0;
            r_hit     <= 1'b0;
        end else begin
            if (issuing) begin
                r_issue <= r_issue + 1'b1;
            end
            if (match) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_pend_idx;
                r_hit_size <= ram_rdata[31:0];
            end
        end
        r_pend_idx <= r_issue[TBL_AW-1:0];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out_hash  <= r_hash;
            r_out_found <= r_hit;
            r_out_full  <= r_is_set && !r_hit && tbl_full;
            if (r_is_set) begin
                r_out_size <= r_size_in;
            end else begin
                r_out_size <= r_hit ? r_hit_size : 32'd0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_size_value = r_out_size;
    assign o_found      = r_out_found;
    assign o_table_full = r_out_full;
    assign o_key_hash   = r_out_hash;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= TBL_CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("entry count moved by more than one");

    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |-> !o_found)
        else $error("full flag together with a hit");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issuing |-> !ram_we)
        else $error("table written during a scan");

endmodule
